FILE: src/gmw_pkg.sv
// ============================================================================
// gmw_pkg: shared definitions for the gray morphology window block
// Holds the configuration register indexes, operation codes, sequencer
// states, the controller/datapath command and status bundles, and the disk
// reach table.
// ============================================================================
package gmw_pkg;

    // Default sizes for the top-level parameters.
    localparam int GMW_MAX_WIDTH  = 1024;
    localparam int GMW_MAX_RADIUS = 3;

    // Frame limits.
    localparam int GMW_MAX_HEIGHT = 4096;
    localparam int GMW_MIN_SIZE   = 4;

    // Port widths fixed by the field definitions.
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DISK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OP     = 3'd4;

    // Operation codes.
    localparam logic [1:0] OP_ERODE  = 2'd0;
    localparam logic [1:0] OP_DILATE = 2'd1;
    localparam logic [1:0] OP_EDGE   = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_TAP,
        S_LAST,
        S_EMIT
    } t_gmw_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the input pixel and set up its outputs
        logic tap_issue;  // read one window tap and step the tap counters
        logic emit;       // load the output register and step the position
    } t_gmw_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_out;    // the pending input pixel completes at least one window
        logic tap_last;   // the current tap is the last of the window
        logic out_last;   // the current output is the last of this transaction
        logic out_free;   // the output register can take a result this cycle
    } t_gmw_sts;

    // Vertical reach at column offset adx for radius r:
    // the disk uses ceil(sqrt(r*r - adx*adx)), the square uses r.
    function automatic logic [1:0] gmw_reach(input logic disk, input logic [1:0] r,
                                             input logic [1:0] adx);
        logic [1:0] d;
        begin
            d = r;
            if (disk) begin
                unique case ({r, adx})
                    4'b01_00: d = 2'd1;
                    4'b10_00: d = 2'd2;
                    4'b10_01: d = 2'd2;
                    4'b11_00: d = 2'd3;
                    4'b11_01: d = 2'd3;
                    4'b11_10: d = 2'd3;
                    default:  d = 2'd0;
                endcase
            end
            return d;
        end
    endfunction

endpackage

FILE: src/gmw_ctrl.sv
// ============================================================================
// gmw_ctrl: sequencer for the gray morphology window
// Takes an input pixel, walks the window taps of each output it completes
// and hands every result to the output register.
// ============================================================================
module gmw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  gmw_pkg::t_gmw_sts i_sts,
    output gmw_pkg::t_gmw_cmd o_cmd
);
    import gmw_pkg::*;

    t_gmw_state r_state;
    t_gmw_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_sts.has_out) begin
                    n_state = S_TAP;
                end
            end
            S_TAP: begin
                if (i_sts.tap_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.out_last ? S_IDLE : S_TAP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_TAP: begin
                o_cmd.tap_issue = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/gmw_datapath.sv
// ============================================================================
// gmw_datapath: line store, tap addressing and min/max unit
// Keeps the most recent rows in a single-port-read memory, forms reflected
// tap addresses, accumulates the window minimum and maximum, and holds the
// output register.
// ============================================================================
module gmw_datapath #(
    parameter int MAX_WIDTH  = gmw_pkg::GMW_MAX_WIDTH,
    parameter int MAX_RADIUS = gmw_pkg::GMW_MAX_RADIUS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gmw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gmw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [gmw_pkg::PIX_W-1:0]         i_gray_pixel,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [gmw_pkg::PIX_W-1:0]         o_result_pixel,
    output logic [gmw_pkg::ROW_W-1:0]         o_out_row,
    output logic [gmw_pkg::OUT_COL_W-1:0]     o_out_col,
    output logic                              o_run_last,
    input  gmw_pkg::t_gmw_cmd                 i_cmd,
    output gmw_pkg::t_gmw_sts                 o_sts
);
    import gmw_pkg::*;

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = CW + 1;

    // Reflects a coordinate into [0, len-1], saturating what stays outside.
    function automatic logic [15:0] reflect(input logic signed [15:0] v,
                                            input logic signed [15:0] len);
        logic signed [15:0] t;
        begin
            t = v;
            if (t < 0) begin
                t = -t - 16'sd1;
            end else if (t >= len) begin
                t = len + len - t - 16'sd1;
            end
            if (t < 0) begin
                t = 16'sd0;
            end
            if (t >= len) begin
                t = len - 16'sd1;
            end
            return t;
        end
    endfunction

    // Configuration registers.
    logic [10:0]           r_cfg_width;
    logic [12:0]           r_cfg_height;
    logic [1:0]            r_cfg_radius;
    logic                  r_cfg_disk;
    logic [1:0]            r_cfg_op;

    // Input position and slot of the next pixel.
    logic [ROW_W-1:0]      r_in_row;
    logic [CW-1:0]         r_in_col;
    logic [SW-1:0]         r_in_slot;

    // Row and slot of the pixel that set up the current outputs.
    logic [ROW_W-1:0]      r_cur_row;
    logic [SW-1:0]         r_cur_slot;

    // Output position walk.
    logic [ROW_W-1:0]      r_orow;
    logic [CW-1:0]         r_ocol;
    logic [ROW_W-1:0]      r_row_end;
    logic [CW-1:0]         r_col_start;
    logic [CW-1:0]         r_col_end;

    // Tap counters.
    logic signed [3:0]     r_dx;
    logic signed [3:0]     r_dy;

    // Read pipeline and accumulator.
    logic [PIX_W-1:0]      mem [DEPTH];
    logic [PIX_W-1:0]      r_rd_data;
    logic                  r_tap_vld;
    logic                  r_tap_first;
    logic                  r_tap_ctr;
    logic [PIX_W-1:0]      r_mn;
    logic [PIX_W-1:0]      r_mx;
    logic [PIX_W-1:0]      r_center;

    // Output register.
    logic                  r_out_vld;
    logic [PIX_W-1:0]      r_out_pix;
    logic [ROW_W-1:0]      r_out_row;
    logic [CW-1:0]         r_out_col;
    logic                  r_out_last;

    logic                  cfg_hit;
    logic [WW-1:0]         eff_w;
    logic [12:0]           eff_h;
    logic [1:0]            eff_r;
    logic signed [3:0]     rs;
    logic                  last_row;
    logic                  last_col;
    logic                  row_ok;
    logic                  col_ok;
    logic [ROW_W-1:0]      row_start;
    logic [ROW_W-1:0]      row_end;
    logic [CW-1:0]         col_start;
    logic [CW-1:0]         col_end;
    logic [1:0]            d_first;
    logic [1:0]            d_cur;
    logic [1:0]            d_next;
    logic signed [3:0]     dx_inc;
    logic [1:0]            adx;
    logic [1:0]            adx_inc;
    logic                  tap_first;
    logic                  tap_last;
    logic [15:0]           cy_full;
    logic [15:0]           cx_full;
    logic [ROW_W-1:0]      cy;
    logic [CW-1:0]         cx;
    logic signed [15:0]    slot_raw;
    logic [SW-1:0]         rd_slot;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [PIX_W-1:0]      fin_pix;
    logic                  out_last;
    logic                  out_free;
    logic [31:0]           out_col_ext;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_IDX_OP);

    // Effective sizes after clamping.
    always_comb begin
        if (r_cfg_width < 11'(GMW_MIN_SIZE)) begin
            eff_w = WW'(GMW_MIN_SIZE);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        if (r_cfg_height < 13'(GMW_MIN_SIZE)) begin
            eff_h = 13'(GMW_MIN_SIZE);
        end else if (r_cfg_height > 13'(GMW_MAX_HEIGHT)) begin
            eff_h = 13'(GMW_MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_height;
        end
        eff_r = (32'(r_cfg_radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : r_cfg_radius;
    end

    assign rs = signed'({2'b00, eff_r});

    // Range of outputs completed by the pending input pixel.
    always_comb begin
        last_row = ({1'b0, r_in_row} == (eff_h - 13'd1));
        last_col = ({1'b0, r_in_col} == (eff_w - WW'(1)));
        row_ok   = last_row || (r_in_row >= ROW_W'(eff_r));
        col_ok   = last_col || (r_in_col >= CW'(eff_r));
        if (last_row) begin
            row_start = ((eff_h - 13'd1) >= 13'(eff_r))
                      ? ROW_W'(eff_h - 13'd1 - 13'(eff_r)) : '0;
            row_end   = ROW_W'(eff_h - 13'd1);
        end else begin
            row_start = r_in_row - ROW_W'(eff_r);
            row_end   = row_start;
        end
        if (last_col) begin
            col_start = ((eff_w - WW'(1)) >= WW'(eff_r))
                      ? CW'(eff_w - WW'(1) - WW'(eff_r)) : '0;
            col_end   = CW'(eff_w - WW'(1));
        end else begin
            col_start = r_in_col - CW'(eff_r);
            col_end   = col_start;
        end
    end

    // Tap walk over the structuring element.
    always_comb begin
        dx_inc    = r_dx + 4'sd1;
        adx       = (r_dx < 0) ? 2'(-r_dx) : 2'(r_dx);
        adx_inc   = (dx_inc < 0) ? 2'(-dx_inc) : 2'(dx_inc);
        d_first   = gmw_reach(r_cfg_disk, eff_r, eff_r);
        d_cur     = gmw_reach(r_cfg_disk, eff_r, adx);
        d_next    = gmw_reach(r_cfg_disk, eff_r, adx_inc);
        tap_first = (r_dx == -rs) && (r_dy == -signed'({2'b00, d_first}));
        tap_last  = (r_dx == rs) && (r_dy == signed'({2'b00, d_cur}));
    end

    // Tap address: reflected coordinates, then the ring slot of the row.
    always_comb begin
        cy_full  = reflect(signed'({4'b0000, r_orow}) + {{12{r_dy[3]}}, r_dy},
                           signed'({3'b000, eff_h}));
        cx_full  = reflect(signed'({{(16-CW){1'b0}}, r_ocol}) + {{12{r_dx[3]}}, r_dx},
                           signed'({{(16-WW){1'b0}}, eff_w}));
        cy       = cy_full[ROW_W-1:0];
        cx       = cx_full[CW-1:0];
        slot_raw = signed'({{(16-SW){1'b0}}, r_cur_slot})
                 - signed'({4'b0000, r_cur_row} - {4'b0000, cy});
        if (slot_raw < 0) begin
            slot_raw = slot_raw + 16'(STORE_ROWS);
        end
        rd_slot  = slot_raw[SW-1:0];
        rd_addr  = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(cx);
        wr_addr  = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    end

    // Final value of the window.
    always_comb begin
        unique case (r_cfg_op)
            OP_DILATE: fin_pix = r_mx;
            OP_EDGE:   fin_pix = r_center - r_mn;
            default:   fin_pix = r_mn;
        endcase
    end

    assign out_last = (r_orow == r_row_end) && (r_ocol == r_col_end);
    assign out_free = !r_out_vld || !i_stall;

    assign o_sts.has_out  = row_ok && col_ok;
    assign o_sts.tap_last = tap_last;
    assign o_sts.out_last = out_last;
    assign o_sts.out_free = out_free;

    // Line store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[wr_addr] <= i_gray_pixel;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd640;
            r_cfg_height <= 13'd480;
            r_cfg_radius <= 2'd1;
            r_cfg_disk   <= 1'b0;
            r_cfg_op     <= OP_ERODE;
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_in_slot    <= '0;
            r_tap_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data[10:0];
                    CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[12:0];
                    CFG_IDX_RADIUS: r_cfg_radius <= i_cfg_data[1:0];
                    CFG_IDX_DISK:   r_cfg_disk   <= i_cfg_data[0];
                    CFG_IDX_OP:     r_cfg_op     <= i_cfg_data[1:0];
                    default:        r_cfg_op     <= r_cfg_op;
                endcase
            end
            if (cfg_hit) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_slot <= '0;
            end else if (i_cmd.accept) begin
                if (last_col) begin
                    r_in_col <= '0;
                    if (last_row) begin
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                    end else begin
                        r_in_row  <= r_in_row + ROW_W'(1);
                        r_in_slot <= (r_in_slot == SW'(STORE_ROWS - 1))
                                   ? '0 : r_in_slot + SW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            r_tap_vld <= i_cmd.tap_issue;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_row   <= r_in_row;
            r_cur_slot  <= r_in_slot;
            r_orow      <= row_start;
            r_ocol      <= col_start;
            r_row_end   <= row_end;
            r_col_start <= col_start;
            r_col_end   <= col_end;
            r_dx        <= -rs;
            r_dy        <= -signed'({2'b00, d_first});
        end else if (i_cmd.tap_issue) begin
            if (tap_last) begin
                r_dx <= -rs;
                r_dy <= -signed'({2'b00, d_first});
            end else if (r_dy == signed'({2'b00, d_cur})) begin
                r_dx <= dx_inc;
                r_dy <= -signed'({2'b00, d_next});
            end else begin
                r_dy <= r_dy + 4'sd1;
            end
        end else if (i_cmd.emit && !out_last) begin
            if (r_ocol == r_col_end) begin
                r_ocol <= r_col_start;
                r_orow <= r_orow + ROW_W'(1);
            end else begin
                r_ocol <= r_ocol + CW'(1);
            end
        end

        r_tap_first <= tap_first;
        r_tap_ctr   <= (r_dx == 4'sd0) && (r_dy == 4'sd0);
        if (r_tap_vld) begin
            if (r_tap_first) begin
                r_mn <= r_rd_data;
                r_mx <= r_rd_data;
            end else begin
                if (r_rd_data < r_mn) begin
                    r_mn <= r_rd_data;
                end
                if (r_rd_data > r_mx) begin
                    r_mx <= r_rd_data;
                end
            end
            if (r_tap_ctr) begin
                r_center <= r_rd_data;
            end
        end

        if (i_cmd.emit) begin
            r_out_pix  <= fin_pix;
            r_out_row  <= r_orow;
            r_out_col  <= r_ocol;
            r_out_last <= out_last;
        end
    end

    assign out_col_ext    = 32'(r_out_col);
    assign o_valid        = r_out_vld;
    assign o_result_pixel = r_out_pix;
    assign o_out_row      = r_out_row;
    assign o_out_col      = out_col_ext[OUT_COL_W-1:0];
    assign o_run_last     = r_out_last;

    // The accumulator has settled before a result is loaded.
    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_tap_vld)
        else $error("result loaded while a tap read is in flight");

    // A new pixel never arrives while taps are still being folded in.
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (!r_tap_vld && !i_cmd.tap_issue))
        else $error("pixel accepted during a window walk");

    // A held result stays until it is taken.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> r_out_vld)
        else $error("stalled result dropped");

    // Tap reads always land in a row slot of the store.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tap_issue |-> (32'(rd_slot) < STORE_ROWS))
        else $error("tap row slot out of range");

endmodule

FILE: src/gray_morphology_window.sv
// ============================================================================
// gray_morphology_window: grayscale erosion, dilation and edge filter
// Streams raster gray pixels through a line store and emits, for each
// completed window, the minimum, the maximum or the center minus minimum.
// ============================================================================
// Usage notes.
// The input channel carries one gray pixel per transaction in raster order
// (i_valid, i_gray_pixel, o_stall). The output channel carries one filtered
// pixel per transaction with its row and column (o_valid, o_result_pixel,
// o_out_row, o_out_col, o_run_last); o_run_last marks the final result
// caused by one input pixel. Borders reflect, and the last column and last
// row of a frame release bursts of results.
// Each result that an input pixel causes comes from a walk over its T
// window taps, where T is (2R+1)^2 for the square window; the single
// read port of the line store means the taps are read one after another.
// o_stall stays high while the window walk runs.
// When the receiver stalls, the result waits in the output register and the
// walk pauses before loading the next one; a new input pixel is taken while
// the last result still waits. Reset clears the position to row 0, column 0
// and loads the register defaults (640 by 480, radius 1, square, erode).
// The line store is not cleared; a register write restarts the frame.
// ============================================================================
module gray_morphology_window #(
    parameter int MAX_WIDTH  = gmw_pkg::GMW_MAX_WIDTH,
    parameter int MAX_RADIUS = gmw_pkg::GMW_MAX_RADIUS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gmw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gmw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [gmw_pkg::PIX_W-1:0]         i_gray_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gmw_pkg::PIX_W-1:0]         o_result_pixel,
    output logic [gmw_pkg::ROW_W-1:0]         o_out_row,
    output logic [gmw_pkg::OUT_COL_W-1:0]     o_out_col,
    output logic                              o_run_last
);
    import gmw_pkg::*;

    // Commands flow from the sequencer to the datapath, status back.
    t_gmw_cmd cmd;
    t_gmw_sts sts;

    gmw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gmw_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_gray_pixel   (i_gray_pixel),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_pixel (o_result_pixel),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_run_last     (o_run_last),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule

FILE: dv/gray_morphology_window_tb.sv
// ----------------------------------------------------------------------------
// gray_morphology_window_tb: self-checking bench for the morphology window
// Streams small frames through the block under several register settings,
// predicts every filtered pixel from a local copy of the line store, and
// compares each output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module gray_morphology_window_tb;
    import gmw_pkg::*;

    // One expected output transaction.
    typedef struct {
        logic [PIX_W-1:0]     pix;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } t_filtered;

    int mismatch_count = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Scoreboard: keeps a copy of the frame position, the registers and the
    // line store, and queues the filtered pixels that each accepted pixel releases.
    class morph_scoreboard;
        logic [7:0]  store [0:7*1024-1];
        int          cur_row, cur_col;
        int          width_reg, height_reg, radius_reg, disk_reg, op_reg;
        t_filtered   pending[$];

        function new();
            cur_row = 0; cur_col = 0;
            width_reg = 640; height_reg = 480; radius_reg = 1;
            disk_reg = 0; op_reg = 0;
            foreach (store[k]) store[k] = 8'd0;
        endfunction

        function void write_reg(int idx, int val);
            case (idx)
                CFG_IDX_WIDTH:  width_reg  = val & 11'h7FF;
                CFG_IDX_HEIGHT: height_reg = val & 13'h1FFF;
                CFG_IDX_RADIUS: radius_reg = val & 2'h3;
                CFG_IDX_DISK:   disk_reg   = val & 1;
                CFG_IDX_OP:     op_reg     = val & 2'h3;
                default: return;
            endcase
            cur_row = 0; cur_col = 0;
        endfunction

        function int mirror(int v, int len);
            if (v < 0) v = -v - 1;
            else if (v >= len) v = 2 * len - v - 1;
            if (v < 0) v = 0;
            if (v >= len) v = len - 1;
            return v;
        endfunction

        // Vertical reach: ceil(sqrt(r*r - dx*dx)) for the disk.
        function int vreach(int r, int dx);
            int t, k;
            k = 0;
            if (disk_reg == 0) return r;
            t = r * r - dx * dx;
            while (k * k < t) k++;
            return k;
        endfunction

        function logic [7:0] pixel_at(int y, int x);
            return store[(y % 7) * 1024 + (x % 1024)];
        endfunction

        function logic [7:0] filter(int orow, int ocol, int r, int w, int h);
            logic [7:0] mn, mx, v;
            int d, cx;
            mn = 8'hFF; mx = 8'h00;
            for (int dx = -r; dx <= r; dx++) begin
                cx = mirror(ocol + dx, w);
                d = vreach(r, dx);
                for (int dy = -d; dy <= d; dy++) begin
                    v = pixel_at(mirror(orow + dy, h), cx);
                    if (v < mn) mn = v;
                    if (v > mx) mx = v;
                end
            end
            if (op_reg == OP_DILATE) return mx;
            if (op_reg == OP_EDGE) return pixel_at(orow, ocol) - mn;
            return mn;
        endfunction

        function void note_pixel(logic [7:0] pix);
            int w, h, r, r0, r1, c0, c1;
            t_filtered e;
            w = (width_reg < 4) ? 4 : (width_reg > 1024 ? 1024 : width_reg);
            h = (height_reg < 4) ? 4 : (height_reg > 4096 ? 4096 : height_reg);
            r = radius_reg;
            if (cur_row >= h) cur_row = 0;
            if (cur_col >= w) cur_col = 0;
            store[(cur_row % 7) * 1024 + cur_col] = pix;
            if (cur_row == h - 1) begin
                r0 = h - 1 - r; if (r0 < 0) r0 = 0; r1 = h - 1;
            end else if (cur_row >= r) begin
                r0 = cur_row - r; r1 = r0;
            end else begin
                r0 = 1; r1 = 0;
            end
            if (cur_col == w - 1) begin
                c0 = w - 1 - r; if (c0 < 0) c0 = 0; c1 = w - 1;
            end else if (cur_col >= r) begin
                c0 = cur_col - r; c1 = c0;
            end else begin
                c0 = 1; c1 = 0;
            end
            for (int orow = r0; orow <= r1; orow++)
                for (int ocol = c0; ocol <= c1; ocol++) begin
                    e.pix = filter(orow, ocol, r, w, h);
                    e.row = ROW_W'(orow); e.col = OUT_COL_W'(ocol);
                    e.last = (orow == r1) && (ocol == c1);
                    pending.push_back(e);
                end
            if (cur_col == w - 1) begin
                cur_col = 0;
                cur_row = (cur_row == h - 1) ? 0 : cur_row + 1;
            end else begin
                cur_col++;
            end
        endfunction

        task check_result(logic [7:0] pix, logic [11:0] row,
                          logic [9:0] col, logic last);
            t_filtered e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d", row, col));
                return;
            end
            e = pending.pop_front();
            if (pix !== e.pix || row !== e.row || col !== e.col || last !== e.last)
                report_mismatch($sformatf(
                    "got pix %0d r %0d c %0d last %0b, want pix %0d r %0d c %0d last %0b",
                    pix, row, col, last, e.pix, e.row, e.col, e.last));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [PIX_W-1:0]      in_pix = '0;
    logic                  out_stall = 1'b0;
    logic                  dut_stall, dut_valid, dut_last;
    logic [PIX_W-1:0]      dut_pix;
    logic [ROW_W-1:0]      dut_row;
    logic [OUT_COL_W-1:0]  dut_col;

    morph_scoreboard sb = new();
    bit stall_quiet = 0;   // when set, the receiver never stalls

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gray_morphology_window DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(dut_stall), .i_gray_pixel(in_pix),
        .o_valid(dut_valid), .i_stall(out_stall),
        .o_result_pixel(dut_pix), .o_out_row(dut_row), .o_out_col(dut_col),
        .o_run_last(dut_last)
    );

    // Output side: sample at the edge, then draw the next stall pattern.
    // Each taken result draws a random stall length, zero when stall_quiet is set.
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n && dut_valid && !out_stall) begin
            sb.check_result(dut_pix, dut_row, dut_col, dut_last);
            stall_left = stall_quiet ? 0 : $urandom_range(0, 11);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        out_stall <= (stall_left > 0);
    end

    // Writes one register at an idle point; a write to a listed index restarts the frame.
    // The task then waits with the enable low so that back-to-back writes never collide.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Sends one pixel transaction, after a random gap when gaps is set, waiting for acceptance.
    // Valid stays high after acceptance; the next call with a gap, or drain(), drops it.
    task automatic send_pixel(input logic [7:0] pix, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1; in_pix <= pix;
        do @(posedge clk); while (dut_stall);
        sb.note_pixel(pix);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input int r, input int dsk,
                             input int op);
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        write_reg(CFG_IDX_RADIUS, r);
        write_reg(CFG_IDX_DISK, dsk);
        write_reg(CFG_IDX_OP, op);
    endtask

    // Streams a number of whole frames; every store entry read belongs to
    // the current frame since frames always restart at row 0.
    task automatic send_frames(input int w, input int h, input int frames,
                               input bit gaps);
        int ew, eh;
        logic [7:0] p;
        ew = (w < 4) ? 4 : w;
        eh = (h < 4) ? 4 : h;
        for (int f = 0; f < frames; f++)
            for (int k = 0; k < ew * eh; k++) begin
                case ($urandom_range(0, 5))
                    0: p = 8'h00;
                    1: p = 8'hFF;
                    default: p = 8'($urandom);
                endcase
                send_pixel(p, gaps);
            end
    endtask

    initial begin
        int w, h;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset radius and erode on a minimal frame, then the
        // extreme settings of each register, the unused operation code
        // acting as erode, clamped sizes, and deep reflection at radius 3.
        write_reg(CFG_IDX_WIDTH, 4);
        write_reg(CFG_IDX_HEIGHT, 4);
        send_frames(4, 4, 1, 0);
        drain();
        configure(1, 0, 3, 1, 3);          // sizes below the minimum clamp to 4
        write_reg(7, 13'h1FFF);            // index beyond the list has no effect
        send_frames(4, 4, 1, 1);
        drain();
        configure(5, 4, 3, 0, OP_EDGE);
        stall_quiet = 1;
        send_frames(5, 4, 1, 0);
        drain();
        stall_quiet = 0;

        // Random phases with random shapes and operations.
        for (int ph = 0; ph < 2; ph++) begin
            w = $urandom_range(4, 6);
            h = $urandom_range(4, 5);
            configure(w, h, $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 3));
            stall_quiet = (ph == 0);
            send_frames(w, h, 1, ph != 1);
            drain();
        end
        stall_quiet = 0;

        // Largest sizes: the register maximum, clamped by the block, with a
        // partial first row only; a following write restarts the frame.
        configure(11'h7FF, 13'h1FFF, 1, 0, OP_DILATE);
        for (int k = 0; k < 6; k++) send_pixel(8'($urandom), 1);
        drain();
        configure(1024, 4096, 2, 1, OP_ERODE);
        for (int k = 0; k < 6; k++) send_pixel(8'($urandom), 1);
        drain();

        if (mismatch_count == 0)
            $display("gray_morphology_window test passed");
        else
            $display("gray_morphology_window test failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("gray_morphology_window test failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/gmw_pkg.sv
src/gmw_ctrl.sv
src/gmw_datapath.sv
src/gray_morphology_window.sv
dv/gray_morphology_window_tb.sv
